@@ hw/rtl/damped_spring_force_defines.svh @@
// Assertion macros used by the top RTL file of the spring force block.
`ifndef DAMPED_SPRING_FORCE_DEFINES_SVH
`define DAMPED_SPRING_FORCE_DEFINES_SVH

// Checks a property at every rising clock edge outside reset.
`define DSF_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checks that a condition in one cycle leads to another in the next cycle.
`define DSF_ASSERT_NEXT(name, ante, cons, msg) \
	`DSF_ASSERT(name, (ante) |=> (cons), msg)

`endif

@@ hw/rtl/dsf_pkg.sv @@
package dsf_pkg;

	localparam int FRAC_BITS = 16;
	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS = FRAC_BITS + 1;
	localparam int U_W = FRAC_BITS + 2;
	localparam int WIDE = 72;

	localparam logic [1:0] REG_STIFFNESS = 2'd0;
	localparam logic [1:0] REG_REST_LENGTH = 2'd1;
	localparam logic [1:0] REG_DAMPING = 2'd2;

	typedef struct packed {
		logic [2:0][31:0] anchor;
		logic [2:0][31:0] body;
		logic [2:0][31:0] vel;
		logic [30:0] inv_mass;
		logic [30:0] step_time;
	} in_t;

	typedef struct packed {
		logic [2:0][31:0] vel;
		logic [2:0][31:0] mag;
		logic [2:0] neg;
		logic [30:0] dt;
		logic [31:0] km;
		logic [31:0] cm;
		logic mnz;
	} ctx_t;

	typedef struct packed {
		ctx_t ctx;
		logic [31:0] d;
		logic apl;
		logic [2:0][U_W-1:0] u;
	} bk_t;

	function automatic logic [31:0] sat32(input logic signed [WIDE-1:0] x);
		logic top_ones;
		logic top_zeros;
		top_ones = &x[WIDE-1:31];
		top_zeros = ~(|x[WIDE-1:31]);
		if (top_ones || top_zeros) begin
			return x[31:0];
		end
		return x[WIDE-1] ? 32'h8000_0000 : 32'h7fff_ffff;
	endfunction

	function automatic logic [31:0] asr_sat(input logic signed [WIDE-1:0] x);
		logic signed [WIDE-1:0] s;
		s = x >>> FRAC_BITS;
		return sat32(s);
	endfunction

endpackage

@@ hw/rtl/dsf_front.sv @@
module dsf_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_vld,
	input  dsf_pkg::in_t     in_data,
	input  logic [30:0]      stiffness,
	input  logic [30:0]      damping,
	output logic             out_vld,
	output dsf_pkg::ctx_t    out_ctx,
	output logic [63:0]      out_sum
);
	import dsf_pkg::*;

	logic [2:0][31:0] dir_c;
	logic vld_s1;
	logic [2:0][31:0] dir_s1;
	logic [2:0][31:0] vel_s1;
	logic [30:0] dt_s1;
	logic mnz_s1;
	logic [61:0] kmp_s1;
	logic [61:0] cmp_s1;

	logic signed [63:0] sq_c [3];
	logic vld_s2;
	logic [63:0] sq_s2 [3];
	ctx_t ctx_s2;
	ctx_t ctx_c;

	logic vld_s3;
	logic [63:0] sum_s3;
	ctx_t ctx_s3;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dir_c[i] = sat32(WIDE'($signed(in_data.anchor[i])) - WIDE'($signed(in_data.body[i])));
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sq_c[i] = $signed(dir_s1[i]) * $signed(dir_s1[i]);
			ctx_c.neg[i] = dir_s1[i][31];
			ctx_c.mag[i] = dir_s1[i][31] ? 32'(-dir_s1[i]) : dir_s1[i];
		end
		ctx_c.vel = vel_s1;
		ctx_c.dt = dt_s1;
		ctx_c.mnz = mnz_s1;
		ctx_c.km = sat32(WIDE'(kmp_s1 >> FRAC_BITS));
		ctx_c.cm = sat32(WIDE'(cmp_s1 >> FRAC_BITS));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dir_s1 <= dir_c;
			vel_s1 <= in_data.vel;
			dt_s1 <= in_data.step_time;
			mnz_s1 <= |in_data.inv_mass;
			kmp_s1 <= 62'(stiffness) * 62'(in_data.inv_mass);
			cmp_s1 <= 62'(damping) * 62'(in_data.inv_mass);
			for (int i = 0; i < 3; i++) begin
				sq_s2[i] <= sq_c[i];
			end
			ctx_s2 <= ctx_c;
			sum_s3 <= sq_s2[0] + sq_s2[1] + sq_s2[2];
			ctx_s3 <= ctx_s2;
		end
	end

	assign out_vld = vld_s3;
	assign out_ctx = ctx_s3;
	assign out_sum = sum_s3;

endmodule

@@ hw/rtl/dsf_sqrt.sv @@
module dsf_sqrt (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_vld,
	input  logic [63:0]    in_sum,
	input  dsf_pkg::ctx_t  in_ctx,
	output logic           out_vld,
	output logic [31:0]    out_len,
	output dsf_pkg::ctx_t  out_ctx
);
	import dsf_pkg::*;

	logic vld_s [SQRT_STEPS];
	logic [63:0] n_s [SQRT_STEPS];
	logic [33:0] rem_s [SQRT_STEPS];
	logic [31:0] root_s [SQRT_STEPS];
	ctx_t ctx_s [SQRT_STEPS];

	for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_stage
		logic v_i;
		logic [63:0] n_i;
		logic [33:0] r_i;
		logic [31:0] q_i;
		ctx_t c_i;
		logic [35:0] tmp;
		logic [35:0] trial;

		if (g == 0) begin : g_first
			assign v_i = in_vld;
			assign n_i = in_sum;
			assign r_i = '0;
			assign q_i = '0;
			assign c_i = in_ctx;
		end else begin : g_next
			assign v_i = vld_s[g-1];
			assign n_i = n_s[g-1];
			assign r_i = rem_s[g-1];
			assign q_i = root_s[g-1];
			assign c_i = ctx_s[g-1];
		end

		assign tmp = {r_i, n_i[63:62]};
		assign trial = {2'b00, q_i, 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				n_s[g] <= {n_i[61:0], 2'b00};
				ctx_s[g] <= c_i;
				if (tmp >= trial) begin
					rem_s[g] <= 34'(tmp - trial);
					root_s[g] <= {q_i[30:0], 1'b1};
				end else begin
					rem_s[g] <= tmp[33:0];
					root_s[g] <= {q_i[30:0], 1'b0};
				end
			end
		end
	end

	assign out_vld = vld_s[SQRT_STEPS-1];
	assign out_len = root_s[SQRT_STEPS-1];
	assign out_ctx = ctx_s[SQRT_STEPS-1];

endmodule

@@ hw/rtl/dsf_div.sv @@
module dsf_div (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_vld,
	input  logic [31:0]    in_len,
	input  dsf_pkg::ctx_t  in_ctx,
	input  logic [30:0]    rest_length,
	output logic           out_vld,
	output dsf_pkg::bk_t   out_data
);
	import dsf_pkg::*;

	typedef struct packed {
		ctx_t ctx;
		logic [31:0] len;
		logic [31:0] d;
		logic apl;
	} hold_t;

	logic vld_s1;
	hold_t hold_s1;

	logic vld_s [DIV_STEPS];
	hold_t hold_s [DIV_STEPS];
	logic [2:0][32:0] r_s [DIV_STEPS];
	logic [2:0][DIV_STEPS-1:0] q_s [DIV_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hold_s1.ctx <= in_ctx;
			hold_s1.len <= in_len;
			hold_s1.d <= sat32(WIDE'({1'b0, rest_length}) - WIDE'(in_len));
			hold_s1.apl <= in_ctx.mnz && (in_len > {1'b0, rest_length});
		end
	end

	for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
		logic v_i;
		hold_t h_i;
		logic [2:0][32:0] r_i;
		logic [2:0][DIV_STEPS-1:0] q_i;
		logic [2:0][32:0] r_n;
		logic [2:0] ge;

		if (g == 0) begin : g_first
			assign v_i = vld_s1;
			assign h_i = hold_s1;
			for (genvar l = 0; l < 3; l++) begin : g_init
				assign r_i[l] = {1'b0, hold_s1.ctx.mag[l]};
			end
			assign q_i = '0;
		end else begin : g_next
			assign v_i = vld_s[g-1];
			assign h_i = hold_s[g-1];
			assign r_i = r_s[g-1];
			assign q_i = q_s[g-1];
		end

		always_comb begin
			for (int l = 0; l < 3; l++) begin
				ge[l] = r_i[l] >= {1'b0, h_i.len};
				r_n[l] = ge[l] ? r_i[l] - {1'b0, h_i.len} : r_i[l];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				hold_s[g] <= h_i;
				for (int l = 0; l < 3; l++) begin
					r_s[g][l] <= {r_n[l][31:0], 1'b0};
					q_s[g][l] <= {q_i[l][DIV_STEPS-2:0], ge[l]};
				end
			end
		end
	end

	always_comb begin
		out_data.ctx = hold_s[DIV_STEPS-1].ctx;
		out_data.d = hold_s[DIV_STEPS-1].d;
		out_data.apl = hold_s[DIV_STEPS-1].apl;
		for (int l = 0; l < 3; l++) begin
			if (hold_s[DIV_STEPS-1].ctx.neg[l]) begin
				out_data.u[l] = U_W'(-U_W'(q_s[DIV_STEPS-1][l]));
			end else begin
				out_data.u[l] = U_W'(q_s[DIV_STEPS-1][l]);
			end
		end
	end

	assign out_vld = vld_s[DIV_STEPS-1];

endmodule

@@ hw/rtl/dsf_back.sv @@
module dsf_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  dsf_pkg::bk_t      in_data,
	output logic              out_vld,
	output logic [2:0][31:0]  out_force,
	output logic              out_apl
);
	import dsf_pkg::*;

	typedef struct packed {
		logic [2:0][U_W-1:0] u;
		logic [31:0] cm;
		logic [30:0] dt;
		logic apl;
	} side_t;

	side_t side_c;
	side_t side_s1, side_s2, side_s3, side_s4, side_s5, side_s6, side_s7;
	logic [7:0] vld_q;

	logic signed [31+U_W:0] pv_s1 [3];
	logic signed [63:0] t1p_s1;
	logic [31:0] v_s2;
	logic [31:0] t1_s2;
	logic signed [63:0] t2p_s3;
	logic [31:0] t1_s3;
	logic [31:0] coeff_s4;
	logic signed [31+U_W:0] pu_s5 [3];
	logic [2:0][31:0] w_s6;
	logic signed [63:0] pf_s7 [3];
	logic [2:0][31:0] force_s8;
	logic apl_s8;

	assign side_c.u = in_data.u;
	assign side_c.cm = in_data.ctx.cm;
	assign side_c.dt = in_data.ctx.dt;
	assign side_c.apl = in_data.apl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[6:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pv_s1[i] <= $signed(in_data.ctx.vel[i]) * $signed(in_data.u[i]);
			end
			t1p_s1 <= $signed(in_data.ctx.km) * $signed(in_data.d);
			side_s1 <= side_c;

			v_s2 <= asr_sat(WIDE'(pv_s1[0]) + WIDE'(pv_s1[1]) + WIDE'(pv_s1[2]));
			t1_s2 <= asr_sat(WIDE'(t1p_s1));
			side_s2 <= side_s1;

			t2p_s3 <= $signed(side_s2.cm) * $signed(v_s2);
			t1_s3 <= t1_s2;
			side_s3 <= side_s2;

			coeff_s4 <= sat32(-WIDE'($signed(t1_s3)) - WIDE'($signed(asr_sat(WIDE'(t2p_s3)))));
			side_s4 <= side_s3;

			for (int i = 0; i < 3; i++) begin
				pu_s5[i] <= $signed(side_s4.u[i]) * $signed(coeff_s4);
			end
			side_s5 <= side_s4;

			for (int i = 0; i < 3; i++) begin
				w_s6[i] <= asr_sat(WIDE'(pu_s5[i]));
			end
			side_s6 <= side_s5;

			for (int i = 0; i < 3; i++) begin
				pf_s7[i] <= $signed(w_s6[i]) * $signed({1'b0, side_s6.dt});
			end
			side_s7 <= side_s6;

			for (int i = 0; i < 3; i++) begin
				force_s8[i] <= side_s7.apl ? asr_sat(WIDE'(pf_s7[i])) : 32'd0;
			end
			apl_s8 <= side_s7.apl;
		end
	end

	assign out_vld = vld_q[7];
	assign out_force = force_s8;
	assign out_apl = apl_s8;

endmodule

@@ hw/rtl/damped_spring_force.sv @@
// Damped bungee spring force unit, fixed point with FRAC_BITS fraction bits.
// Requests enter on the s_axis channel: anchor, body position and velocity,
// inverse mass and time step packed in s_axis_tdata. Each request gives one
// result on the m_axis channel: the three force components in m_axis_tdata
// and the applied flag in m_axis_tuser. When the spring is slack, the body is
// immovable or the points coincide, the force is zero and applied is low.
// The unit is a fixed pipeline that accepts one request every cycle unless
// the receiver stalls it. A request passes input arithmetic stages, a
// square root at one result bit per stage, a division at one quotient bit
// per stage, and multiply and saturate stages ending in the output
// register. Data words are Q16.16.
// The spring registers are written through the cfg port, which is always
// ready; write them only while no request is in flight.
// Reset clears all valid bits and loads stiffness 1.0, rest length 1.0 and
// damping 0. When the receiver stalls, the whole pipeline holds and
// s_axis_tready falls; nothing is dropped or repeated.
`include "damped_spring_force_defines.svh"

module damped_spring_force (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	// anchor_x, anchor_y, anchor_z, body_x, body_y, body_z, vel_x, vel_y, vel_z,
	// inv_mass, step_time, two zero bits
	input  logic [351:0]  s_axis_tdata,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	// force_x, force_y, force_z
	output logic [95:0]   m_axis_tdata,
	// applied
	output logic [0:0]    m_axis_tuser,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [1:0]    cfg_index,
	input  logic [30:0]   cfg_data
);
	import dsf_pkg::*;

	logic [30:0] stiffness_q;
	logic [30:0] rest_length_q;
	logic [30:0] damping_q;
	logic en;
	in_t in_data;

	logic fr_vld;
	ctx_t fr_ctx;
	logic [63:0] fr_sum;
	logic sq_vld;
	logic [31:0] sq_len;
	ctx_t sq_ctx;
	logic dv_vld;
	bk_t dv_data;
	logic [2:0][31:0] bk_force;
	logic bk_apl;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stiffness_q <= 31'd65536;
			rest_length_q <= 31'd65536;
			damping_q <= 31'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_STIFFNESS: stiffness_q <= cfg_data;
				REG_REST_LENGTH: rest_length_q <= cfg_data;
				REG_DAMPING: damping_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			in_data.anchor[i] = s_axis_tdata[32*i +: 32];
			in_data.body[i] = s_axis_tdata[96 + 32*i +: 32];
			in_data.vel[i] = s_axis_tdata[192 + 32*i +: 32];
		end
		in_data.inv_mass = s_axis_tdata[318:288];
		in_data.step_time = s_axis_tdata[349:319];
	end

	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	dsf_front u_front (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_vld(s_axis_tvalid), .in_data(in_data),
		.stiffness(stiffness_q), .damping(damping_q),
		.out_vld(fr_vld), .out_ctx(fr_ctx), .out_sum(fr_sum)
	);

	dsf_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_vld(fr_vld), .in_sum(fr_sum), .in_ctx(fr_ctx),
		.out_vld(sq_vld), .out_len(sq_len), .out_ctx(sq_ctx)
	);

	dsf_div u_div (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_vld(sq_vld), .in_len(sq_len), .in_ctx(sq_ctx),
		.rest_length(rest_length_q),
		.out_vld(dv_vld), .out_data(dv_data)
	);

	dsf_back u_back (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_vld(dv_vld), .in_data(dv_data),
		.out_vld(m_axis_tvalid), .out_force(bk_force), .out_apl(bk_apl)
	);

	assign m_axis_tdata = {bk_force[2], bk_force[1], bk_force[0]};
	assign m_axis_tuser = bk_apl;

	`DSF_ASSERT(a_slack_zero, (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == 96'd0), "force without applied flag")
	`DSF_ASSERT_NEXT(a_stall_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")
	`DSF_ASSERT_NEXT(a_cfg_stiff, cfg_valid && cfg_index == REG_STIFFNESS, stiffness_q == $past(cfg_data), "stiffness write lost")

endmodule
